### hw/rtl/cpmn_pkg.sv
`default_nettype none

package cpmn_pkg;

  localparam int CHANNELS_DEF  = 128;
  localparam int NUM_SLOTS_DEF = 16;
  localparam int ADC_BITS      = 12;

  localparam int OP_W      = 2;
  localparam int SLOT_W    = 4;
  localparam int CHAN_W    = 7;
  localparam int SMP_W     = 12;
  localparam int Q4_W      = 16;
  localparam int EV_W      = 16;
  localparam int DFLT_W    = 12;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int SUM_W = 34;
  localparam int SQ_W  = 46;
  localparam int CNT_W = 21;

  // digit-serial multiplier: 48 x 16 per cycle, three digits
  localparam int MUL_D_W    = 16;
  localparam int MUL_DIGITS = 3;
  localparam int MUL_A_W    = MUL_D_W * MUL_DIGITS;
  localparam int MUL_P_W    = MUL_A_W + MUL_D_W;
  localparam int ACC_W      = 80;

  localparam int VAR_SHIFT = 8;
  localparam int DVD_W     = 76;
  localparam int DVS_W     = 2 * CNT_W;
  localparam int QUO_W     = 32;
  localparam int SQRT_W    = 32;
  localparam int ROOT_W    = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [SMP_W-1:0] SMP_MASK =
      (ADC_BITS >= SMP_W) ? '1 : SMP_W'((2 ** ADC_BITS) - 1);

  localparam logic [EV_W-1:0]   RST_EVENTS_TO_AVERAGE = EV_W'(500);
  localparam logic [EV_W-1:0]   RST_MINIMAL_EVENTS    = EV_W'(15);
  localparam logic [DFLT_W-1:0] RST_DEFAULT_OFFSET    = DFLT_W'(3000);
  localparam logic [DFLT_W-1:0] RST_DEFAULT_NOISE     = DFLT_W'(0);

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE    = 2'd0,
    OP_READ      = 2'd1,
    OP_END_EVENT = 2'd2,
    OP_BEGIN_RUN = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EVENTS_TO_AVERAGE = 2'd0,
    CFG_MINIMAL_EVENTS    = 2'd1,
    CFG_DEFAULT_OFFSET    = 2'd2,
    CFG_DEFAULT_NOISE     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t               op;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [CHAN_W-1:0] chan;
    logic [SMP_W-1:0]  sample;
  } cmd_t;

  typedef struct packed {
    logic [EV_W-1:0]   events_to_average;
    logic [EV_W-1:0]   minimal_events;
    logic [DFLT_W-1:0] default_offset;
    logic [DFLT_W-1:0] default_noise;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic [CNT_W-1:0] cnt;
  } acc_t;

  typedef struct packed {
    logic [Q4_W-1:0]   offset_q4;
    logic [Q4_W-1:0]   noise_q4;
    logic              using_defaults;
    logic [SLOT_W-1:0] read_slot;
    logic [CHAN_W-1:0] read_channel;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SAMPLE,
    ST_LOAD,
    ST_DIV_MEAN,
    ST_MUL,
    ST_VAR_GO,
    ST_DIV_VAR,
    ST_SQRT,
    ST_EMIT
  } bst_t;

  function automatic logic [Q4_W-1:0] sat16(input logic [QUO_W-1:0] v);
    logic [Q4_W-1:0] r;
    r = (|v[QUO_W-1:Q4_W]) ? '1 : v[Q4_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cpmn_div.sv
`default_nettype none

module cpmn_div import cpmn_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [QUO_W-1:0]      quotient
);

  localparam int CNT_BITS = $clog2(DVD_W + 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [DVD_W-1:0]    dvd_r;
  logic [DVS_W-1:0]    dvs_r;
  logic [DVS_W-1:0]    rem_r;
  logic [QUO_W-1:0]    quo_r;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           ge;

  // restoring division, one dividend bit per cycle
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

### hw/rtl/cpmn_sqrt.sv
`default_nettype none

module cpmn_sqrt import cpmn_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SQRT_W-1:0] x,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  logic              busy_r;
  logic              done_r;
  logic [SQRT_W-1:0] x_r;
  logic [SQRT_W-1:0] res_r;
  logic [SQRT_W-1:0] b_r;

  logic [SQRT_W:0] t;
  logic            ge;

  always_comb begin
    t  = {1'b0, res_r} + {1'b0, b_r};
    ge = ({1'b0, x_r} >= t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && b_r == SQRT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // digit-by-digit root, two radicand bits per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      res_r <= '0;
      b_r   <= SQRT_W'(1) << (SQRT_W - 2);
    end else if (busy_r) begin
      if (ge) begin
        x_r   <= x_r - t[SQRT_W-1:0];
        res_r <= (res_r >> 1) + b_r;
      end else begin
        res_r <= res_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/cpmn_front.sv
`default_nettype none

module cpmn_front import cpmn_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [SLOT_W-1:0] in_apv_slot,
  input  wire logic [CHAN_W-1:0] in_channel,
  input  wire logic [SMP_W-1:0]  in_sample_value,
  input  wire logic              clearing,
  output logic                   cq_valid,
  output cmd_t                   cq_cmd,
  input  wire logic              cq_pop
);

  localparam int FQ_DEPTH = 2;

  cmd_t       q_r [FQ_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  cmd_t cmd_in;
  logic do_push;
  logic do_pop;

  always_comb begin
    cmd_in.op     = op_t'(in_op);
    cmd_in.hit    = (32'(in_apv_slot) < NUM_SLOTS) && (32'(in_channel) < CHANNELS);
    cmd_in.slot   = in_apv_slot;
    cmd_in.chan   = in_channel;
    cmd_in.sample = in_sample_value & SMP_MASK;
  end

  // no beats taken while the accumulator memory is being swept
  assign full     = (cnt_r == 2'(FQ_DEPTH)) || clearing;
  assign do_push  = push && !full;
  assign cq_valid = (cnt_r != 2'd0);
  assign do_pop   = cq_pop && cq_valid;
  assign cq_cmd   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= cmd_in;
  end

endmodule

`default_nettype wire

### hw/rtl/cpmn_back.sv
`default_nettype none

module cpmn_back import cpmn_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic cq_valid,
  input  wire cmd_t cq_cmd,
  output logic      cq_pop,
  output logic      clearing,
  output logic      out_valid,
  output res_t      out_res,
  input  wire logic out_pop
);

  localparam int DEPTH  = NUM_SLOTS * CHANNELS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [1:0]        K_LAST   = 2'(MUL_DIGITS - 1);

  bst_t state_r, state_nxt;

  acc_t              mem_r [DEPTH];
  acc_t              rd_data_r;
  logic [ADDR_W-1:0] clr_r;
  logic [EV_W-1:0]   ev_r;
  cmd_t              cmd_r;
  logic [ADDR_W-1:0] idx_r;

  logic [Q4_W-1:0]    offset_r;
  logic [Q4_W-1:0]    noise_r;
  logic               defaults_r;
  logic [SUM_W-1:0]   s_r;
  logic [DVS_W-1:0]   nn_r;
  logic [MUL_A_W-1:0] a_r;
  logic [MUL_A_W-1:0] b_r;
  logic [ACC_W-1:0]   acc_r;
  logic [1:0]         k_r;
  logic               phase_r;
  logic               out_valid_r;
  res_t               out_r;

  logic [ADDR_W-1:0]  cq_idx;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  acc_t               mem_wdata;
  logic [2*SMP_W-1:0] smp_sq;
  logic [MUL_P_W-1:0] prod;
  logic [ACC_W-1:0]   prod_sh;
  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic               div_done;
  logic [QUO_W-1:0]   div_q;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [ROOT_W-1:0]  sqrt_root;
  logic               use_dflt;

  assign cq_idx   = ADDR_W'(32'(cq_cmd.slot) * CHANNELS + 32'(cq_cmd.chan));
  assign use_dflt = (ev_r < cfg.minimal_events);
  assign smp_sq   = (2*SMP_W)'(cmd_r.sample) * (2*SMP_W)'(cmd_r.sample);
  assign prod     = MUL_P_W'(a_r) * MUL_P_W'(b_r[MUL_D_W-1:0]);
  assign prod_sh  = ACC_W'(prod) << {k_r, 4'b0};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:    if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (cq_valid) begin
          unique case (cq_cmd.op)
            OP_SAMPLE:
              state_nxt = (cq_cmd.hit && ev_r < cfg.events_to_average) ? ST_SAMPLE : ST_IDLE;
            OP_READ:
              state_nxt = (use_dflt || !cq_cmd.hit) ? ST_EMIT : ST_LOAD;
            OP_END_EVENT: state_nxt = ST_IDLE;
            OP_BEGIN_RUN: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SAMPLE:   state_nxt = ST_IDLE;
      ST_LOAD:     state_nxt = (rd_data_r.cnt == '0) ? ST_EMIT : ST_DIV_MEAN;
      ST_DIV_MEAN: if (div_done) state_nxt = ST_MUL;
      ST_MUL:      if (k_r == K_LAST && phase_r) state_nxt = ST_VAR_GO;
      ST_VAR_GO:   state_nxt = ST_DIV_VAR;
      ST_DIV_VAR:  if (div_done) state_nxt = ST_SQRT;
      ST_SQRT:     if (sqrt_done) state_nxt = ST_EMIT;
      ST_EMIT:     if (!out_valid_r) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cq_pop       = (state_r == ST_IDLE) && cq_valid;
    clearing     = (state_r == ST_CLEAR);
    mem_we       = 1'b0;
    mem_waddr    = idx_r;
    mem_wdata    = '0;
    div_start    = 1'b0;
    div_dividend = DVD_W'({rd_data_r.sum, 4'b0});
    div_divisor  = DVS_W'(rd_data_r.cnt);
    sqrt_start   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
      end
      ST_SAMPLE: begin
        mem_we        = (rd_data_r.cnt != CNT_MAX);
        mem_wdata.sum = rd_data_r.sum + SUM_W'(cmd_r.sample);
        mem_wdata.sq  = rd_data_r.sq + SQ_W'(smp_sq);
        mem_wdata.cnt = rd_data_r.cnt + CNT_W'(1);
      end
      ST_LOAD:    div_start = (rd_data_r.cnt != '0);
      ST_VAR_GO: begin
        div_start    = 1'b1;
        div_dividend = {acc_r[DVD_W-VAR_SHIFT-1:0], {VAR_SHIFT{1'b0}}};
        div_divisor  = nn_r;
      end
      ST_DIV_VAR: sqrt_start = div_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_waddr] <= mem_wdata;
    rd_data_r <= mem_r[cq_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      ev_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + ADDR_W'(1);
      if (cq_pop) begin
        if (cq_cmd.op == OP_END_EVENT && ev_r != '1) ev_r <= ev_r + EV_W'(1);
        if (cq_cmd.op == OP_BEGIN_RUN) ev_r <= '0;
      end
      if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      if (state_r == ST_EMIT && !out_valid_r) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      cmd_r      <= cq_cmd;
      idx_r      <= cq_idx;
      defaults_r <= use_dflt;
      offset_r   <= use_dflt ? {cfg.default_offset, 4'b0} : '0;
      noise_r    <= use_dflt ? {cfg.default_noise, 4'b0} : '0;
    end
    if (state_r == ST_LOAD) begin
      nn_r    <= DVS_W'(rd_data_r.cnt) * DVS_W'(rd_data_r.cnt);
      s_r     <= rd_data_r.sum;
      a_r     <= MUL_A_W'(rd_data_r.sq);
      b_r     <= MUL_A_W'(rd_data_r.cnt);
      acc_r   <= '0;
      k_r     <= '0;
      phase_r <= 1'b0;
    end
    if (state_r == ST_DIV_MEAN && div_done) offset_r <= sat16(div_q);
    // n*sq first, then s*s subtracted; result is never negative
    if (state_r == ST_MUL) begin
      acc_r <= phase_r ? (acc_r - prod_sh) : (acc_r + prod_sh);
      b_r   <= b_r >> MUL_D_W;
      k_r   <= k_r + 2'd1;
      if (k_r == K_LAST) begin
        k_r <= '0;
        if (!phase_r) begin
          phase_r <= 1'b1;
          a_r     <= MUL_A_W'(s_r);
          b_r     <= MUL_A_W'(s_r);
        end
      end
    end
    if (state_r == ST_SQRT && sqrt_done) noise_r <= sqrt_root;
    if (state_r == ST_EMIT && !out_valid_r) begin
      out_r.offset_q4      <= offset_r;
      out_r.noise_q4       <= noise_r;
      out_r.using_defaults <= defaults_r;
      out_r.read_slot      <= cmd_r.slot;
      out_r.read_channel   <= cmd_r.chan;
    end
  end

  cpmn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  cpmn_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .x     (div_q),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

### hw/rtl/channel_pedestal_mean_noise.sv
`default_nettype none
// channel    handshake        payload
// input      push / full      in_op, in_apv_slot, in_channel, in_sample_value
// result     empty / pop      out_offset_q4, out_noise_q4, out_using_defaults,
//                             out_read_slot, out_read_channel
// config     cfg_we           cfg_index, cfg_wdata
//
// Samples do a read-modify-write of the accumulator memory; event and run
// ops only update the event counter. A measured read runs two passes of the
// bit-serial divider on a 76-bit dividend, 6 multiplier digits and 16 root
// steps. After reset, full stays high while the memory is zeroed. A 2-beat
// command queue and a result register let input and output stall
// independently.

module channel_pedestal_mean_noise import cpmn_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [OP_W-1:0]      in_op,
  input  wire logic [SLOT_W-1:0]    in_apv_slot,
  input  wire logic [CHAN_W-1:0]    in_channel,
  input  wire logic [SMP_W-1:0]     in_sample_value,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [Q4_W-1:0]           out_offset_q4,
  output logic [Q4_W-1:0]           out_noise_q4,
  output logic                      out_using_defaults,
  output logic [SLOT_W-1:0]         out_read_slot,
  output logic [CHAN_W-1:0]         out_read_channel,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t cfg_r;
  logic clearing;
  logic cq_valid;
  cmd_t cq_cmd;
  logic cq_pop;
  logic out_valid;
  res_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.events_to_average <= RST_EVENTS_TO_AVERAGE;
      cfg_r.minimal_events    <= RST_MINIMAL_EVENTS;
      cfg_r.default_offset    <= RST_DEFAULT_OFFSET;
      cfg_r.default_noise     <= RST_DEFAULT_NOISE;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_EVENTS_TO_AVERAGE: cfg_r.events_to_average <= cfg_wdata[EV_W-1:0];
        CFG_MINIMAL_EVENTS:    cfg_r.minimal_events    <= cfg_wdata[EV_W-1:0];
        CFG_DEFAULT_OFFSET:    cfg_r.default_offset    <= cfg_wdata[DFLT_W-1:0];
        CFG_DEFAULT_NOISE:     cfg_r.default_noise     <= cfg_wdata[DFLT_W-1:0];
      endcase
    end
  end

  cpmn_front #(
    .CHANNELS  (CHANNELS),
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_op           (in_op),
    .in_apv_slot     (in_apv_slot),
    .in_channel      (in_channel),
    .in_sample_value (in_sample_value),
    .clearing        (clearing),
    .cq_valid        (cq_valid),
    .cq_cmd          (cq_cmd),
    .cq_pop          (cq_pop)
  );

  cpmn_back #(
    .CHANNELS  (CHANNELS),
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cq_valid  (cq_valid),
    .cq_cmd    (cq_cmd),
    .cq_pop    (cq_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_pop   (pop)
  );

  assign empty              = !out_valid;
  assign out_offset_q4      = out_res.offset_q4;
  assign out_noise_q4       = out_res.noise_q4;
  assign out_using_defaults = out_res.using_defaults;
  assign out_read_slot      = out_res.read_slot;
  assign out_read_channel   = out_res.read_channel;

endmodule

`default_nettype wire
